// File: design/dtq_pkg.sv
// Shared types, codes and helpers for the deadline timer queue.
`default_nettype none

package dtq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int MAX_OUT = 16;
  localparam int N_W = $clog2(MAX_OUT + 1);

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] delay;
    logic [7:0]  tag;
  } dtq_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tag_out;
    logic       status;
    logic       last;
  } dtq_out_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic rd_head;
    logic wr_en;
    logic wr_new;
    logic idx_dec;
    logic count_inc;
    logic pop;
    logic out_load;
    logic out_ack;
    logic out_last;
  } dtq_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic idx_zero;
    logic ins_stop;
    logic rel_due;
    logic rel_stop;
    logic n_zero;
    logic out_free;
  } dtq_sts_t;

  // True when time a is at or before time b, modulo 2^32.
  function automatic logic not_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = b - a;
    return ~diff[31];
  endfunction

endpackage

`default_nettype wire

// File: design/dtq_datapath.sv
// Datapath of the deadline timer queue: time, circular entry memory, result register.
`default_nettype none

module dtq_datapath #(
  parameter int DEPTH = dtq_pkg::DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dtq_pkg::dtq_in_t  in_data,
  input  wire dtq_pkg::dtq_cmd_t cmd,
  output dtq_pkg::dtq_sts_t      sts,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output dtq_pkg::dtq_out_t      out_data
);
  import dtq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [31:0]   mem_dl [DEPTH];
  logic [7:0]    mem_tag [DEPTH];

  logic [31:0]   now_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [31:0]   dl_new_r;
  logic [7:0]    tag_new_r;
  logic          full_r;
  logic [N_W-1:0] n_r;
  logic [7:0]    pend_tag_r;
  logic [31:0]   rd_dl_r;
  logic [7:0]    rd_tag_r;
  logic          out_valid_r;
  dtq_out_t      out_data_r;

  logic [CW-1:0] rd_lidx;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_dl;
  logic [7:0]    wr_tag;
  logic [AW-1:0] head_inc;

  // Map a logical queue position onto a slot of the circular store.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] lidx);
    logic [SW-1:0] sum;
    sum = {{(SW-AW){1'b0}}, head} + {1'b0, lidx};
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign rd_lidx  = cmd.rd_head ? '0 : idx_r - CW'(1);
  assign rd_addr  = phys(head_r, rd_lidx);
  assign wr_addr  = phys(head_r, idx_r);
  assign wr_dl    = cmd.wr_new ? dl_new_r : rd_dl_r;
  assign wr_tag   = cmd.wr_new ? tag_new_r : rd_tag_r;
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_dl[wr_addr]  <= wr_dl;
      mem_tag[wr_addr] <= wr_tag;
    end
    if (cmd.rd_en) begin
      rd_dl_r  <= mem_dl[rd_addr];
      rd_tag_r <= mem_tag[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (in_data.opcode == OP_TICK) begin
          now_r <= now_r + 32'd1;
          n_r   <= '0;
        end else begin
          idx_r <= count_r;
        end
      end
      if (cmd.idx_dec) begin
        idx_r <= idx_r - CW'(1);
      end
      if (cmd.count_inc) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.pop) begin
        count_r <= count_r - CW'(1);
        head_r  <= head_inc;
        n_r     <= n_r + N_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dl_new_r  <= now_r + {16'd0, in_data.delay};
      tag_new_r <= in_data.tag;
      full_r    <= (count_r == CW'(DEPTH));
    end
    if (cmd.pop) begin
      pend_tag_r <= rd_tag_r;
    end
    if (cmd.out_load) begin
      if (cmd.out_ack) begin
        out_data_r.kind    <= KIND_ACK;
        out_data_r.tag_out <= tag_new_r;
        out_data_r.status  <= full_r ? STATUS_FULL : STATUS_OK;
        out_data_r.last    <= 1'b1;
      end else begin
        out_data_r.kind    <= KIND_RELEASE;
        out_data_r.tag_out <= pend_tag_r;
        out_data_r.status  <= STATUS_OK;
        out_data_r.last    <= cmd.out_last;
      end
    end
  end

  always_comb begin
    sts.count_zero = (count_r == '0);
    sts.full       = (count_r == CW'(DEPTH));
    sts.idx_zero   = (idx_r == '0);
    sts.ins_stop   = not_after(rd_dl_r, dl_new_r);
    sts.rel_due    = not_after(rd_dl_r, now_r);
    sts.rel_stop   = (n_r == N_W'(MAX_OUT - 1)) || (count_r == CW'(1));
    sts.n_zero     = (n_r == '0);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten before it was taken");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0) && (n_r < N_W'(MAX_OUT)))
    else $error("release from an empty queue or past the per-tick limit");
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.count_inc |-> !full_r && (count_r < CW'(DEPTH)))
    else $error("insert into a full queue");
`endif

endmodule

`default_nettype wire

// File: design/dtq_ctrl.sv
// Control state machine of the deadline timer queue.
`default_nettype none

module dtq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_opcode,
  output logic                  in_ready,
  input  wire dtq_pkg::dtq_sts_t sts,
  output dtq_pkg::dtq_cmd_t      cmd
);
  import dtq_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_INS_RD   = 7'b0000010,
    ST_INS_CHK  = 7'b0000100,
    ST_ACK      = 7'b0001000,
    ST_REL_RD   = 7'b0010000,
    ST_REL_CHK  = 7'b0100000,
    ST_REL_LAST = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_opcode == OP_TICK) begin
            state_nxt = sts.count_zero ? ST_IDLE : ST_REL_RD;
          end else begin
            state_nxt = sts.full ? ST_ACK : ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (sts.idx_zero) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          state_nxt     = ST_ACK;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        cmd.wr_en = 1'b1;
        if (sts.ins_stop) begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          state_nxt     = ST_ACK;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = ST_INS_RD;
        end
      end
      ST_ACK: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ack  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_REL_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_head = 1'b1;
        state_nxt   = ST_REL_CHK;
      end
      ST_REL_CHK: begin
        if (sts.rel_due) begin
          if (sts.n_zero || sts.out_free) begin
            cmd.out_load = !sts.n_zero;
            cmd.pop      = 1'b1;
            state_nxt    = sts.rel_stop ? ST_REL_LAST : ST_REL_RD;
          end
        end else begin
          state_nxt = sts.n_zero ? ST_IDLE : ST_REL_LAST;
        end
      end
      ST_REL_LAST: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_en && cmd.wr_en))
    else $error("memory read and write in the same cycle");
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !cmd.out_ack && !cmd.out_last) |=> (state_r == ST_REL_RD)
      || (state_r == ST_REL_LAST))
    else $error("release beat without last not followed by more work");
  a_release_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REL_LAST) |-> !sts.n_zero)
    else $error("final release beat with nothing held");
`endif

endmodule

`default_nettype wire

// File: design/deadline_timer_queue.sv
// Top level of the deadline timer queue: controller plus datapath.
`default_nettype none

// The block keeps a 32-bit time counter and up to DEPTH pending entries sorted by
// deadline, with equal deadlines kept in arrival order. A schedule beat computes
// its deadline as the current time plus delay and is answered with one beat: an
// acknowledgement with status ok, or status full when the queue already holds
// DEPTH entries, in which case the entry is dropped. A tick beat advances time
// by one and then releases from the head every entry whose deadline has arrived
// (wrap-safe, modulo 2^32), at most sixteen per tick, the final one marked with
// last; a tick with nothing due gives no beat at all. The entries live in a
// circular single-port store, so one entry is visited at a time. A schedule beat
// walks from the back of the queue toward the head, reading and comparing one
// entry at a time and shifting each later entry back by one slot until it finds
// the place for the new entry; a refused schedule on a full queue does no walk.
// A tick reads and checks entries from the head one at a time; a tick on an empty
// queue checks none. Whenever the output register is still occupied when a result
// is to be loaded, the block stalls. A new beat is taken as soon as the previous
// one's last result sits in the output register, even while that result still
// waits to be taken.
module deadline_timer_queue #(
  parameter int DEPTH = dtq_pkg::DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire dtq_pkg::dtq_in_t  in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output dtq_pkg::dtq_out_t      out_data
);
  import dtq_pkg::*;

  // Commands from the controller and status back from the datapath.
  dtq_cmd_t cmd;
  dtq_sts_t sts;

  // The controller sequences the insertion walk and the release walk.
  dtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds time, the entry store and the result register.
  dtq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: tb/sv/deadline_timer_queue_checker.sv
// Checker for the deadline timer queue: tracks the pending entries and compares every result beat.
module deadline_timer_queue_checker #(
  parameter int DEPTH = dtq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  dtq_pkg::dtq_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  dtq_pkg::dtq_out_t out_data,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import dtq_pkg::*;

  // Shadow copy of the block's timer and its deadline-sorted entry list, head in slot 0.
  logic [31:0] clock_now;
  logic [31:0] slot_deadline [DEPTH];
  logic [7:0]  slot_tag [DEPTH];
  int          slot_count;
  dtq_out_t    replies_q [$];
  dtq_out_t    oldest;

  // Time a is at or before time b when b - a, read as a signed 32-bit value, is not negative.
  function automatic logic at_or_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] gap;
    gap = b - a;
    return !gap[31];
  endfunction

  // Applies one accepted request to the shadow list and queues the replies it causes.
  task automatic serve_request(input dtq_in_t req);
    logic [31:0] due_at;
    dtq_out_t    beat;
    int          pos;
    int          released;
    int          i;
    if (req.opcode == OP_SCHEDULE) begin
      due_at = clock_now + {16'd0, req.delay};
      beat.kind = KIND_ACK;
      beat.tag_out = req.tag;
      beat.last = 1'b1;
      if (slot_count >= DEPTH) begin
        beat.status = STATUS_FULL;
      end else begin
        beat.status = STATUS_OK;
        pos = 0;
        while (pos < slot_count && at_or_before(slot_deadline[pos], due_at)) pos++;
        for (i = slot_count; i > pos; i--) begin
          slot_deadline[i] = slot_deadline[i-1];
          slot_tag[i] = slot_tag[i-1];
        end
        slot_deadline[pos] = due_at;
        slot_tag[pos] = req.tag;
        slot_count++;
      end
      replies_q.push_back(beat);
    end else begin
      clock_now = clock_now + 32'd1;
      released = 0;
      while (released < MAX_OUT && slot_count > 0 &&
             at_or_before(slot_deadline[0], clock_now)) begin
        beat.kind = KIND_RELEASE;
        beat.tag_out = slot_tag[0];
        beat.status = STATUS_OK;
        for (i = 0; i < slot_count - 1; i++) begin
          slot_deadline[i] = slot_deadline[i+1];
          slot_tag[i] = slot_tag[i+1];
        end
        slot_count--;
        released++;
        beat.last = !(released < MAX_OUT && slot_count > 0 &&
                      at_or_before(slot_deadline[0], clock_now));
        replies_q.push_back(beat);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clock_now = '0;
      slot_count = 0;
      fail_count = 0;
      replies_q.delete();
    end else begin
      if (in_valid && in_ready) serve_request(in_data);
      if (out_valid && out_ready) begin
        if (replies_q.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing, got %p",
                   $time, out_data);
          fail_count++;
        end else begin
          oldest = replies_q.pop_front();
          check_field("kind", 8'(oldest.kind), 8'(out_data.kind));
          check_field("tag_out", oldest.tag_out, out_data.tag_out);
          check_field("status", 8'(oldest.status), 8'(out_data.status));
          check_field("last", 8'(oldest.last), 8'(out_data.last));
        end
      end
    end
    pending = replies_q.size();
  end

endmodule

// File: tb/sv/deadline_timer_queue_tb.sv
// Testbench top for the deadline timer queue: clock, reset, stimulus, receiver and verdict.
module deadline_timer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtq_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung. The longest
  // legitimate quiet stretch is the receiver hold-off plus one item's worth of work.
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_AT     = 120;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_AT        = 200;
  localparam int RANDOM_ITEMS    = 444;
  // A tick may release nothing, so after the last expected beat we keep watching for
  // well over the worst-case item time to catch any stray beat.
  localparam int SETTLE_CYCLES   = 100;
  localparam int FAR_ENTRIES     = 5;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  dtq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dtq_out_t out_data;

  int fail_count;
  int pending;
  int sent_count = 0;

  always #1 clk = ~clk;

  deadline_timer_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  deadline_timer_queue_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Presents one beat and holds it until the block takes it. Called right after a rising
  // edge; returns right after the accepting edge, so a following beat can be presented in
  // the same step without valid ever dropping.
  task automatic offer(input logic op, input logic [15:0] dly, input logic [7:0] tg);
    dtq_in_t beat;
    beat.opcode = op;
    beat.delay = dly;
    beat.tag = tg;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic schedule_entry(input logic [15:0] dly, input logic [7:0] tg);
    offer(OP_SCHEDULE, dly, tg);
  endtask

  // Delay and tag are don't-care on a tick, so they carry random noise.
  task automatic tick();
    offer(OP_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endtask

  task automatic rest_sender(input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every predicted beat has come out. The pending count is
  // updated at the rising edge, so it is read at the falling edge.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // The receiver switches between always ready, coin-flip and mostly stalled stretches.
  // Once the sender has pushed enough beats it holds off for a long stretch so the block's
  // output register fills and the input side backs up.
  initial begin : receiver
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    forever begin
      if (!held && sent_count >= HOLD_OFF_AT) begin
        held = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk) out_ready <= 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(5, 60);
        repeat (span) begin
          @(posedge clk);
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Any stretch this long without a single beat on either channel means the block hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("** deadline_timer_queue: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int issued;
    int burst;
    int k;
    int far_left;
    int pick;
    issued = 0;
    far_left = FAR_ENTRIES;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A tick on an empty queue only moves time on and gives no beat.
    tick();
    // Zero delay with the lowest tag: due on the very next tick.
    schedule_entry(16'h0000, 8'h00);
    tick();
    // Sixteen entries with one shared deadline fill the queue; equal deadlines must come
    // back in arrival order. The seventeenth schedule is refused with the full status.
    for (k = 0; k < DEPTH_DEFAULT; k++) schedule_entry(16'd1, 8'(k * 17));
    schedule_entry(16'hFFFF, 8'hA5);
    // One tick releases all sixteen at once, the most a single tick may give.
    tick();
    // The longest delay with the highest tag stays queued for the whole run. The later
    // entry with the shorter delay has to be inserted ahead of the earlier one.
    schedule_entry(16'hFFFF, 8'hFF);
    schedule_entry(16'd3, 8'h33);
    schedule_entry(16'd2, 8'h22);
    tick();
    tick();

    // Random traffic in bursts. Ticks and short delays dominate so entries come due often
    // and the queue swings between nearly empty and full. A handful of long delays cover
    // the upper delay bits; they stay queued, so their number is capped.
    while (issued < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 20);
      for (k = 0; k < burst && issued < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 50) begin
          tick();
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 3 && far_left > 0) begin
            far_left--;
            schedule_entry(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
          end else if (pick < 12) begin
            schedule_entry(16'($urandom_range(0, 120)), 8'($urandom_range(0, 255)));
          end else begin
            schedule_entry(16'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
          end
        end
        issued++;
        // Once mid-run the sender waits for every outstanding beat before going on.
        if (issued == DRAIN_AT) wait_for_quiet();
      end
      if ($urandom_range(0, 3) == 0) rest_sender(0);
      else rest_sender($urandom_range(1, 12));
    end

    wait_for_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** deadline_timer_queue: PASSED **");
    end else begin
      $display("** deadline_timer_queue: FAILED **");
    end
    $finish;
  end

endmodule
